// File: hw/rtl/command_record_playback_sequencer_assert.svh
// Assertion macros for the record/playback sequencer.
`ifndef COMMAND_RECORD_PLAYBACK_SEQUENCER_ASSERT_SVH
`define COMMAND_RECORD_PLAYBACK_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define CRPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/crps_pkg.sv
package crps_pkg;

  localparam int LOG_DEPTH = 256;
  localparam int GAP_BITS  = 16;

  localparam int ADDR_W = $clog2(LOG_DEPTH);
  localparam int POS_W  = $clog2(LOG_DEPTH + 1);

  localparam logic [GAP_BITS-1:0] GAP_MAX = {GAP_BITS{1'b1}};

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_RECORD = 2'd1;
  localparam logic [1:0] REQ_MODE   = 2'd2;

  typedef struct packed {
    logic                cmd_we;
    logic [ADDR_W-1:0]   cmd_addr;
    logic [7:0]          cmd_data;
    logic                gap_we;
    logic [ADDR_W-1:0]   gap_addr;
    logic [GAP_BITS-1:0] gap_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
  } log_req_t;

endpackage

// File: hw/rtl/command_record_playback_sequencer.sv
// Ticks, record words and mode changes into recording take effect in the cycle after acceptance.
// A replayed command reaches the output through the synchronous log read and then the
// output register that holds the result.
// Throughput: 1 word per cycle while the output is not stalled; input waits out each log read.
// Reset clears mode, counters and playback state; log contents stay undefined until
// recorded, with no clearing pass.
`include "command_record_playback_sequencer_assert.svh"

module command_record_playback_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [15:0] s_tdata,  // [7:0] command, [8] to_playback, [15:9] zero
  input  logic [1:0] s_tuser,   // [1:0] req_type
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] played_command
  output logic       m_tuser,   // [0] has_command
  output logic       m_tlast    // playback_done
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                          state;
  logic [crps_pkg::POS_W-1:0]      position;
  logic [crps_pkg::ADDR_W-1:0]     last_entry;
  logic                            log_nonempty;
  logic [crps_pkg::GAP_BITS-1:0]   tick_count;
  logic [crps_pkg::GAP_BITS-1:0]   wait_count;
  logic                            in_playback;
  logic                            playing;

  logic                            accept;
  logic [1:0]                      req_type;
  logic [7:0]                      command;
  logic                            to_playback;
  logic                            log_room;
  logic                            rec_ok;
  logic                            play_tick;
  logic                            play_start;
  logic                            out_load;
  crps_pkg::log_req_t              log_req;
  logic [7:0]                      rd_cmd;
  logic [crps_pkg::GAP_BITS-1:0]   rd_gap;
  logic [crps_pkg::GAP_BITS-1:0]   gap_eff;
  logic                            done;

  assign req_type    = s_tuser;
  assign command     = s_tdata[7:0];
  assign to_playback = s_tdata[8];

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign log_room   = position < crps_pkg::POS_W'(crps_pkg::LOG_DEPTH);
  assign rec_ok     = accept && (req_type == crps_pkg::REQ_RECORD) && !in_playback && log_room;
  assign play_tick  = accept && (req_type == crps_pkg::REQ_TICK) && in_playback && playing &&
                      (wait_count <= crps_pkg::GAP_BITS'(1));
  assign play_start = accept && (req_type == crps_pkg::REQ_MODE) && to_playback && log_nonempty;
  // output register gets a new word this cycle
  assign out_load   = (state == S_READ) ||
                      (accept && (req_type == crps_pkg::REQ_MODE) && to_playback && !log_nonempty);

  always_comb begin
    log_req.cmd_we   = rec_ok;
    log_req.cmd_addr = position[crps_pkg::ADDR_W-1:0];
    log_req.cmd_data = command;
    log_req.gap_we   = rec_ok && (position != '0);
    log_req.gap_addr = crps_pkg::ADDR_W'(position - crps_pkg::POS_W'(1));
    log_req.gap_data = tick_count;
    log_req.rd_en    = play_tick || play_start;
    log_req.rd_addr  = play_start ? '0 : position[crps_pkg::ADDR_W-1:0];
  end

  crps_log u_log (
    .clk    (clk),
    .req    (log_req),
    .rd_cmd (rd_cmd),
    .rd_gap (rd_gap)
  );

  // a zero gap still waits one tick
  assign gap_eff = (rd_gap == '0) ? crps_pkg::GAP_BITS'(1) : rd_gap;
  assign done    = position >= crps_pkg::POS_W'(last_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      position     <= '0;
      last_entry   <= '0;
      log_nonempty <= 1'b0;
      tick_count   <= '0;
      wait_count   <= '0;
      in_playback  <= 1'b0;
      playing      <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      m_tuser      <= 1'b0;
      m_tlast      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              crps_pkg::REQ_TICK: begin
                if (!in_playback) begin
                  if (position != '0 && tick_count != crps_pkg::GAP_MAX) begin
                    tick_count <= tick_count + crps_pkg::GAP_BITS'(1);
                  end
                end else if (playing) begin
                  if (play_tick) begin
                    state <= S_READ;
                  end else begin
                    wait_count <= wait_count - crps_pkg::GAP_BITS'(1);
                  end
                end
              end
              crps_pkg::REQ_RECORD: begin
                if (rec_ok) begin
                  last_entry   <= position[crps_pkg::ADDR_W-1:0];
                  log_nonempty <= 1'b1;
                  tick_count   <= '0;
                  position     <= position + crps_pkg::POS_W'(1);
                end
              end
              crps_pkg::REQ_MODE: begin
                position   <= '0;
                wait_count <= '0;
                if (!to_playback) begin
                  playing      <= 1'b0;
                  in_playback  <= 1'b0;
                  last_entry   <= '0;
                  log_nonempty <= 1'b0;
                  tick_count   <= '0;
                end else begin
                  in_playback <= 1'b1;
                  playing     <= log_nonempty;
                  if (log_nonempty) begin
                    state   <= S_READ;
                  end else begin
                    // empty log: done word only
                    m_tvalid <= 1'b1;
                    m_tdata  <= '0;
                    m_tuser  <= 1'b0;
                    m_tlast  <= 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b1;
          m_tdata  <= rd_cmd;
          m_tuser  <= 1'b1;
          m_tlast  <= done;
          position <= position + crps_pkg::POS_W'(1);
          if (done) begin
            playing    <= 1'b0;
            last_entry <= '0;
            wait_count <= '0;
          end else begin
            wait_count <= gap_eff;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CRPS_ASSERT_NOW(a_read_out_free, state == S_READ, !m_tvalid, "output busy during log read")
  `CRPS_ASSERT_NEXT(a_read_gives_word, state == S_READ, m_tvalid && m_tuser, "log read gave no word")
  `CRPS_ASSERT_NEXT(a_record_ignored_in_playback,
    accept && req_type == crps_pkg::REQ_RECORD && in_playback, $stable(position),
    "record moved position during playback")
  `CRPS_ASSERT_NOW(a_position_range, 1'b1,
    position <= crps_pkg::POS_W'(crps_pkg::LOG_DEPTH), "position beyond log depth")

endmodule

// File: hw/rtl/crps_log.sv
module crps_log (
  input  logic                             clk,
  input  crps_pkg::log_req_t               req,
  output logic [7:0]                       rd_cmd,
  output logic [crps_pkg::GAP_BITS-1:0]    rd_gap
);

  logic [7:0]                    cmd_mem [crps_pkg::LOG_DEPTH];
  logic [crps_pkg::GAP_BITS-1:0] gap_mem [crps_pkg::LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (req.cmd_we) begin
      cmd_mem[req.cmd_addr] <= req.cmd_data;
    end
    if (req.rd_en) begin
      rd_cmd <= cmd_mem[req.rd_addr];
    end
  end

  // gap of entry n is written when entry n+1 is recorded
  always_ff @(posedge clk) begin
    if (req.gap_we) begin
      gap_mem[req.gap_addr] <= req.gap_data;
    end
    if (req.rd_en) begin
      rd_gap <= gap_mem[req.rd_addr];
    end
  end

endmodule

// File: sim/tb_command_record_playback_sequencer.sv
`timescale 1ns / 1ps

module tb_command_record_playback_sequencer;

  // req_type code that the block does not use
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 1200;

  typedef struct packed {
    logic [7:0] cmd;
    logic       cmd_valid;
    logic       done;
  } played_t;

  // Tracks the log and playback state, queues the replayed words it predicts.
  class replay_predictor;
    bit [7:0]                    cmd_log [crps_pkg::LOG_DEPTH];
    bit [crps_pkg::GAP_BITS-1:0] gap_log [crps_pkg::LOG_DEPTH];
    bit [crps_pkg::POS_W-1:0]    position;
    bit [crps_pkg::ADDR_W-1:0]   last_entry;
    bit                          log_nonempty;
    bit                          in_playback;
    bit                          playing;
    bit [crps_pkg::GAP_BITS-1:0] tick_count;
    bit [crps_pkg::GAP_BITS-1:0] wait_count;
    played_t                     expected_q[$];
    int                          mismatches;

    function void play_next();
      played_t r;
      bit [crps_pkg::GAP_BITS-1:0] g;
      g = gap_log[position[crps_pkg::ADDR_W-1:0]];
      r.cmd = cmd_log[position[crps_pkg::ADDR_W-1:0]];
      r.cmd_valid = 1'b1;
      wait_count = (g == '0) ? crps_pkg::GAP_BITS'(1) : g;
      position++;
      r.done = (position > last_entry);
      if (r.done) begin
        playing = 1'b0;
        last_entry = '0;
        wait_count = '0;
      end
      expected_q.push_back(r);
    endfunction

    function void accept_word(bit [1:0] req, bit [7:0] cmd, bit to_pb);
      played_t r;
      unique case (req)
        crps_pkg::REQ_TICK: begin
          if (!in_playback) begin
            if (position > 0 && tick_count != crps_pkg::GAP_MAX) tick_count++;
          end else if (playing) begin
            if (wait_count > 1) wait_count--;
            else play_next();
          end
        end
        crps_pkg::REQ_RECORD: begin
          if (!in_playback && position < crps_pkg::LOG_DEPTH) begin
            cmd_log[position[crps_pkg::ADDR_W-1:0]] = cmd;
            last_entry = position[crps_pkg::ADDR_W-1:0];
            log_nonempty = 1'b1;
            if (position > 0) gap_log[position[crps_pkg::ADDR_W-1:0] - 1'b1] = tick_count;
            tick_count = '0;
            position++;
          end
        end
        crps_pkg::REQ_MODE: begin
          position = '0;
          wait_count = '0;
          playing = 1'b0;
          if (!to_pb) begin
            in_playback = 1'b0;
            last_entry = '0;
            log_nonempty = 1'b0;
            tick_count = '0;
          end else begin
            in_playback = 1'b1;
            if (!log_nonempty) begin
              r = '{cmd: 8'd0, cmd_valid: 1'b0, done: 1'b1};
              expected_q.push_back(r);
            end else begin
              playing = 1'b1;
              play_next();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_played(bit [7:0] cmd, bit cmd_valid, bit done);
      played_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word cmd=%h valid=%b done=%b",
                   $realtime, cmd, cmd_valid, done);
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.cmd !== cmd || exp_r.cmd_valid !== cmd_valid || exp_r.done !== done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp cmd=%h valid=%b done=%b, got cmd=%h valid=%b done=%b",
                   $realtime, exp_r.cmd, exp_r.cmd_valid, exp_r.done,
                   cmd, cmd_valid, done);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] command, [8] to_playback
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] played_command
  logic        m_tuser;        // [0] has_command
  logic        m_tlast;        // playback_done

  replay_predictor sb;
  bit gaps_on = 1'b1;
  int useful_words;
  int cycle_count;

  command_record_playback_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL command_record_playback_sequencer");
      $finish;
    end
  end

  // result side: check accepted words, random backpressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_played(m_tdata, m_tuser, m_tlast);
    m_tready <= gaps_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  task automatic send_word(input bit [1:0] req, input bit [7:0] cmd, input bit to_pb);
    while (gaps_on && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, to_pb, cmd};
    s_tuser <= req;
    do @(posedge clk); while (!s_tready);
    sb.accept_word(req, cmd, to_pb);
    if (req != REQ_UNUSED) useful_words++;
  endtask

  task automatic send_tick();
    send_word(crps_pkg::REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_noise();
    if ($urandom_range(1))
      send_word(REQ_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
    else
      send_word(crps_pkg::REQ_RECORD, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic tick_through_playback();
    while (sb.playing) send_tick();
  endtask

  task automatic random_session();
    int n;
    int r;
    if ($urandom_range(7) != 0) send_word(crps_pkg::REQ_MODE, 8'($urandom_range(255)), 1'b0);
    // ticks ahead of the first command are dropped
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_tick();
    n = ($urandom_range(39) == 0) ? $urandom_range(200, 270) : $urandom_range(1, 12);
    repeat (n) begin
      send_word(crps_pkg::REQ_RECORD, 8'($urandom_range(255)), 1'($urandom_range(1)));
      r = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      repeat (r) send_tick();
      if ($urandom_range(24) == 0) send_noise();
    end
    send_word(crps_pkg::REQ_MODE, 8'($urandom_range(255)), 1'b1);
    while (sb.playing) begin
      r = $urandom_range(99);
      if (r == 0) send_word(crps_pkg::REQ_MODE, 8'($urandom_range(255)), 1'b1);
      else if (r == 1) send_word(crps_pkg::REQ_MODE, 8'($urandom_range(255)), 1'b0);
      else if (r < 5) send_noise();
      else send_tick();
    end
    repeat ($urandom_range(0, 2)) send_tick();
    if ($urandom_range(4) == 0) drain();
  endtask

  initial begin
    int start_words;
    sb = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle-mode corner cases, then a short record/replay
    send_tick();
    send_word(crps_pkg::REQ_MODE, 8'h00, 1'b1);        // empty log: done only
    send_tick();
    send_word(crps_pkg::REQ_RECORD, 8'h3C, 1'b0);      // ignored in playback
    send_word(REQ_UNUSED, 8'hFF, 1'b1);
    send_word(crps_pkg::REQ_MODE, 8'hFF, 1'b0);
    send_word(crps_pkg::REQ_RECORD, 8'h00, 1'b1);
    send_tick();
    send_tick();
    send_word(crps_pkg::REQ_RECORD, 8'hFF, 1'b0);
    send_word(crps_pkg::REQ_RECORD, 8'hA5, 1'b0);      // zero gap plays after one tick
    repeat (3) send_tick();
    send_word(crps_pkg::REQ_RECORD, 8'h5A, 1'b1);
    send_word(crps_pkg::REQ_MODE, 8'h00, 1'b1);
    tick_through_playback();
    send_tick();
    send_word(crps_pkg::REQ_MODE, 8'h00, 1'b1);        // replays entry 0 alone
    drain();

    // full log, one extra record dropped
    send_word(crps_pkg::REQ_MODE, 8'h00, 1'b0);
    repeat (crps_pkg::LOG_DEPTH + 1) begin
      send_word(crps_pkg::REQ_RECORD, 8'($urandom_range(255)), 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) send_tick();
    end
    repeat (2) send_tick();
    send_word(crps_pkg::REQ_MODE, 8'h00, 1'b1);
    tick_through_playback();
    drain();

    start_words = useful_words;
    while (useful_words - start_words < RANDOM_WORDS) begin
      // a long stretch with both sides running flat out
      gaps_on = !((useful_words - start_words) inside {[700:1100]});
      random_session();
    end
    gaps_on = 1'b1;
    drain();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS command_record_playback_sequencer");
    end else begin
      $display("FAIL command_record_playback_sequencer");
    end
    $finish;
  end

endmodule
